FILE: rtl/core/double_ended_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Double-ended queue unit: assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DEQ_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Next-cycle implication, disabled during reset.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

FILE: rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue unit: package
// Operation and status codes, field widths and the result record.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int WORD_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int IN_FIELDS_W  = OP_W + VALUE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DATA_W + STATUS_W + COUNT_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NULL  = 2'd3
  } status_t;

  // data_out sits in the low bits, is_empty on top
  typedef struct packed {
    logic                is_empty;
    logic [COUNT_W-1:0]  count;
    status_t             status;
    logic [DATA_W-1:0]   data_out;
  } res_t;

endpackage

FILE: rtl/core/deq_ram.sv
// ----------------------------------------------------------------------------
// Double-ended queue unit: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue unit: controller
// Head and occupancy registers, ring address arithmetic, sequencer.
// ----------------------------------------------------------------------------
`include "double_ended_queue_unit_macros.svh"

module deq_ctrl #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = deq_pkg::WORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  deq_pkg::op_t                 in_op,
  input  logic [deq_pkg::VALUE_W-1:0]  in_value,
  output logic                         wr_en,
  output logic [$clog2(DEPTH)-1:0]     wr_addr,
  output logic [WORD_WIDTH-1:0]        wr_data,
  output logic [$clog2(DEPTH)-1:0]     rd_addr,
  input  logic [WORD_WIDTH-1:0]        rd_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output deq_pkg::res_t                res
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_HOLD} state_t;

  state_t          state;
  logic [AW-1:0]   head;
  logic [CW-1:0]   occ;

  logic            in_fire;
  logic [WORD_WIDTH-1:0] word;
  logic            is_push, is_pop, is_peek, is_front;
  logic            q_full, q_empty, push_ok;
  logic [SW-1:0]   tail_sum, back_sum;
  logic [AW-1:0]   tail, back, head_prev, head_inc;

  status_t         status_next;
  logic [CW-1:0]   occ_next;
  logic [AW-1:0]   head_next;
  logic            read_needed;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign word     = WORD_WIDTH'(in_value);

  assign is_push  = (in_op == OP_PUSH_FRONT) || (in_op == OP_PUSH_BACK);
  assign is_pop   = (in_op == OP_POP_FRONT)  || (in_op == OP_POP_BACK);
  assign is_peek  = (in_op == OP_PEEK_FRONT) || (in_op == OP_PEEK_BACK);
  assign is_front = (in_op == OP_PUSH_FRONT) || (in_op == OP_POP_FRONT) ||
                    (in_op == OP_PEEK_FRONT);

  assign q_full   = (occ == CW'(DEPTH));
  assign q_empty  = (occ == '0);
  assign push_ok  = is_push && (word != '0) && !q_full;

  // ring positions: sums stay below twice the depth, so one subtract wraps
  assign tail_sum  = SW'(head) + SW'(occ);
  assign back_sum  = tail_sum - SW'(1);
  assign tail      = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign back      = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign head_prev = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc  = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  assign wr_en     = in_fire && push_ok;
  assign wr_addr   = is_front ? head_prev : tail;
  assign wr_data   = word;
  assign rd_addr   = is_front ? head : back;
  assign res_valid = (state == S_HOLD);

  // operation decode: null is refused before the full check
  always_comb begin
    status_next = ST_OK;
    occ_next    = occ;
    head_next   = head;
    read_needed = 1'b0;
    if (is_push) begin
      if (word == '0) begin
        status_next = ST_NULL;
      end else if (q_full) begin
        status_next = ST_FULL;
      end else begin
        if (is_front) begin
          head_next = head_prev;
        end
        occ_next = occ + CW'(1);
      end
    end else if (is_pop || is_peek) begin
      if (q_empty) begin
        status_next = ST_EMPTY;
      end else begin
        read_needed = 1'b1;
        if (is_pop) begin
          if (is_front) begin
            head_next = head_inc;
          end
          occ_next = occ - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      occ   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            head         <= head_next;
            occ          <= occ_next;
            res.data_out <= '0;
            res.status   <= status_next;
            res.count    <= COUNT_W'(occ_next);
            res.is_empty <= (occ_next == '0);
            state        <= read_needed ? S_READ : S_HOLD;
          end
        end
        S_READ: begin
          res.data_out <= DATA_W'(rd_data);
          state        <= S_HOLD;
        end
        S_HOLD: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DEQ_ASSERT(a_occ_bound, clk, rst, 1'b1, occ <= CW'(DEPTH))
  `DEQ_ASSERT(a_head_bound, clk, rst, 1'b1, head <= AW'(DEPTH - 1))
  `DEQ_ASSERT_NEXT(a_push_grows, clk, rst, in_fire && push_ok, occ == $past(occ) + CW'(1))
  `DEQ_ASSERT_NEXT(a_read_then_hold, clk, rst, state == S_READ, state == S_HOLD)
  `DEQ_ASSERT_NEXT(a_hold_stable, clk, rst, (state == S_HOLD) && !res_ready,
    (state == S_HOLD) && $stable(res))

endmodule

FILE: rtl/core/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// Double-ended queue unit: top level
// Ring-buffer deque of data words with front/back push, pop and peek.
// ----------------------------------------------------------------------------
// Each input item carries one operation and a word; each returns exactly one
// result item with the popped or peeked word, a status, the count after the
// operation and an empty flag. Words live in a DEPTH-entry synchronous RAM
// addressed as a ring from the head pointer; a zero word means null and is
// refused on push. One item is in work at a time: a push, a no-op or a
// failed access passes from idle to the hold state, a successful pop or
// peek through a read state first for the registered RAM read. The
// result register lets a new item be accepted while the previous result is
// still waiting on m_tready. The RAM needs no clearing after reset: only
// entries written by a push are ever read back.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = deq_pkg::WORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // operation [2:0], value [34:3], zero pad above
  input  logic [deq_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // data_out [31:0], status [33:32], count [40:34], is_empty [41], zero pad
  output logic [deq_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  op_t                   in_op;
  logic [VALUE_W-1:0]    in_value;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [WORD_WIDTH-1:0] wr_data, rd_data;

  logic                  res_valid, res_ready;
  res_t                  res;
  res_t                  out_q;   // output register

  assign in_op    = op_t'(s_tdata[OP_W-1:0]);
  assign in_value = s_tdata[OP_W +: VALUE_W];

  deq_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (in_op),
    .in_value  (in_value),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // result slot is free when empty or being drained this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_q};

endmodule

FILE: tb/sv/deq_result_checker.sv
// ----------------------------------------------------------------------------
// Double-ended queue unit: result checker
// Watches both stream channels and keeps its own copy of the ring. Each
// accepted input item is applied to that copy to get the result it should
// give. Each accepted result is then compared with the oldest one awaited.
// ----------------------------------------------------------------------------
module deq_result_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [deq_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [deq_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                              errors,
  output int                              pending
);
  import deq_pkg::*;

  logic [DATA_W-1:0] ring [DEPTH];
  int                head_pos;
  int                fill;
  res_t              awaited_results [$];
  int                fails;

  // Applies one operation to the shadow ring and returns the result it gives.
  function automatic res_t deque_apply(logic [OP_W-1:0] op, logic [VALUE_W-1:0] word);
    res_t r;
    int   pos;
    r = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        // null is refused before the full check
        if (word == '0) begin
          r.status = ST_NULL;
        end else if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head_pos = (head_pos + DEPTH - 1) % DEPTH;
            pos      = head_pos;
          end else begin
            pos = (head_pos + fill) % DEPTH;
          end
          ring[pos] = word;
          fill++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) pos = head_pos;
          else pos = (head_pos + fill - 1) % DEPTH;
          r.data_out = ring[pos];
          if (op == OP_POP_FRONT) begin
            head_pos = (head_pos + 1) % DEPTH;
            fill--;
          end else if (op == OP_POP_BACK) begin
            fill--;
          end
        end
      end
      default: ;  // unused codes leave everything alone
    endcase
    r.count    = COUNT_W'(fill);
    r.is_empty = (fill == 0);
    return r;
  endfunction

  task automatic flag_mismatch(string what, res_t want, res_t seen);
    fails++;
    if (fails <= 10)
      $display({"%0t: %s: want data %h st %0d cnt %0d empty %0b, ",
                "got data %h st %0d cnt %0d empty %0b"},
               $time, what, want.data_out, want.status, want.count, want.is_empty,
               seen.data_out, seen.status, seen.count, seen.is_empty);
  endtask

  always @(posedge clk) begin
    res_t seen;
    res_t want;
    if (rst) begin
      head_pos = 0;
      fill     = 0;
      awaited_results.delete();
    end else begin
      // results first: a result can never belong to the item taken at this edge
      if (m_tvalid && m_tready) begin
        seen = res_t'(m_tdata[OUT_FIELDS_W-1:0]);
        if (awaited_results.size() == 0) begin
          flag_mismatch("unexpected result", '0, seen);
        end else begin
          want = awaited_results.pop_front();
          if (seen.data_out !== want.data_out || seen.status !== want.status ||
              seen.count !== want.count || seen.is_empty !== want.is_empty)
            flag_mismatch("result mismatch", want, seen);
        end
      end
      if (s_tvalid && s_tready)
        awaited_results.push_back(deque_apply(s_tdata[OP_W-1:0],
                                              s_tdata[OP_W +: VALUE_W]));
    end
    errors  <= fails;
    pending <= awaited_results.size();
  end

endmodule

FILE: tb/sv/tb_double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// Double-ended queue unit: testbench top
// Drives operation items into the deque and takes its results, with random
// idle bursts on both sides, a long receiver hold-off and drain pauses. The
// result checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_unit;
  import deq_pkg::*;

  // codes 6 and 7 carry no operation but still return a result
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam int ITEMS_TOTAL = 1150;
  localparam int CALM_FROM   = 1000;  // no idling from here to the end
  localparam int LONG_HOLD   = 400;   // receiver hold-off, in cycles
  localparam int STALL_LIMIT = 4000;  // cycles with no item moving on either side
  localparam int TAIL_CYCLES = 20;

  typedef enum int {FILL_UP, DRAIN_OUT, CHURN} mix_t;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // operation [2:0], value [34:3], zero pad above
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // data_out [31:0], status [33:32], count [40:34], is_empty [41], zero pad
  logic [OUT_TDATA_W-1:0] m_tdata;

  int errors;
  int pending;
  int items_sent = 0;
  int quiet      = 0;

  // stimulus-side controls; all but tx_idle_on are read by the receiver process
  bit calm        = 1'b0;
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  bit hold_req    = 1'b0;
  bit hold_served = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_ended_queue_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  deq_result_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  // Offers one item and returns at the edge where it is taken.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] word);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, word, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic maybe_gap();
    if (!calm && tx_idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Sender stops until every awaited result has been taken.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [OP_W-1:0] pick_op(mix_t mix);
    int r;
    bit back;
    r    = $urandom_range(0, 99);
    back = $urandom_range(0, 1);
    case (mix)
      FILL_UP: begin
        if (r < 85) return back ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if (r < 93) return back ? OP_PEEK_BACK : OP_PEEK_FRONT;
        return back ? OP_POP_BACK : OP_POP_FRONT;
      end
      DRAIN_OUT: begin
        if (r < 80) return back ? OP_POP_BACK : OP_POP_FRONT;
        if (r < 90) return back ? OP_PEEK_BACK : OP_PEEK_FRONT;
        return back ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end
      default: begin
        if (r < 96) return OP_W'($urandom_range(OP_PUSH_FRONT, OP_PEEK_BACK));
        return back ? OP_UNUSED_HI : OP_UNUSED_LO;
      end
    endcase
  endfunction

  // mostly random words, with null and the extremes now and then
  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return VALUE_W'(1);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: ready with random idle bursts; one long hold-off on request.
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog on cycles where nothing moves.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("FAIL double_ended_queue_unit");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    mix_t mix;
    int   phase_len;
    bit   first_phase;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty accesses, null pushes, extremes at both ends, unused codes
    send_item(OP_POP_FRONT, $urandom);                 maybe_gap();
    send_item(OP_POP_BACK, $urandom);                  maybe_gap();
    send_item(OP_PEEK_FRONT, $urandom);                maybe_gap();
    send_item(OP_PEEK_BACK, $urandom);                 maybe_gap();
    send_item(OP_PUSH_FRONT, '0);                      maybe_gap();
    send_item(OP_PUSH_BACK, '0);                       maybe_gap();
    send_item(OP_UNUSED_LO, $urandom);                 maybe_gap();
    send_item(OP_PUSH_BACK, 32'hFFFF_FFFF);            maybe_gap();
    send_item(OP_PUSH_FRONT, 32'h0000_0001);           maybe_gap();
    send_item(OP_PUSH_BACK, 32'h8000_0000);            maybe_gap();
    send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);           maybe_gap();
    send_item(OP_PEEK_FRONT, '1);                      maybe_gap();
    send_item(OP_PEEK_BACK, '0);                       maybe_gap();
    send_item(OP_UNUSED_HI, '1);                       maybe_gap();
    send_item(OP_PUSH_FRONT, '0);                      maybe_gap();
    send_item(OP_POP_BACK, $urandom);                  maybe_gap();
    send_item(OP_POP_FRONT, $urandom);                 maybe_gap();
    send_item(OP_POP_FRONT, $urandom);                 maybe_gap();
    send_item(OP_POP_BACK, $urandom);                  maybe_gap();
    send_item(OP_PEEK_FRONT, $urandom);                maybe_gap();
    // single word seen from both ends
    send_item(OP_PUSH_FRONT, 32'hAAAA_5555);           maybe_gap();
    send_item(OP_POP_BACK, $urandom);                  maybe_gap();
    send_item(OP_PUSH_BACK, 32'h5555_AAAA);            maybe_gap();
    send_item(OP_PEEK_FRONT, $urandom);                maybe_gap();
    send_item(OP_POP_FRONT, $urandom);
    wait_drained();

    // Random phases; the first fills the ring and opens with the receiver holding off
    mix         = FILL_UP;
    first_phase = 1'b1;
    hold_req    = 1'b1;
    while (items_sent < ITEMS_TOTAL) begin
      phase_len   = first_phase ? 110 : $urandom_range(20, 120);
      first_phase = 1'b0;
      tx_idle_on  = $urandom_range(0, 2) != 0;
      rx_idle_on  = $urandom_range(0, 2) != 0;
      repeat (phase_len) begin
        if (items_sent < ITEMS_TOTAL) begin
          calm = items_sent >= CALM_FROM;
          send_item(pick_op(mix), pick_word());
          maybe_gap();
        end
      end
      if (!calm && $urandom_range(0, 4) == 0) wait_drained();
      mix = mix_t'($urandom_range(FILL_UP, CHURN));
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS double_ended_queue_unit");
    end else begin
      $display("FAIL double_ended_queue_unit");
    end
    $finish;
  end

endmodule
